// File: rtl/global_control_register_file_defines.svh
// Assertion macros used by the global control register file RTL.
`ifndef GLOBAL_CONTROL_REGISTER_FILE_DEFINES_SVH
`define GLOBAL_CONTROL_REGISTER_FILE_DEFINES_SVH
`ifndef SYNTHESIS
`define GCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define GCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GCR_ASSERT_IMP(lbl, ante, cons, msg)
`define GCR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/gcr_pkg.sv
package gcr_pkg;

  localparam int unsigned APB_AW = 4;

  localparam logic [1:0] CFG_STRAPS = 2'd0;
  localparam logic [1:0] CFG_MDL    = 2'd1;
  localparam logic [1:0] CFG_DRAM   = 2'd2;

  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_RELOAD = 2'd2;
  localparam logic [1:0] ACT_BAD    = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_RO     = 2'd2;

  localparam logic [9:0] W_PDID     = 10'd0;
  localparam logic [9:0] W_PWRON    = 10'd1;
  localparam logic [9:0] W_INTSR    = 10'd16;
  localparam logic [9:0] W_RESSR    = 10'd27;
  localparam logic [9:0] W_RLOCKR1  = 10'd28;
  localparam logic [9:0] W_MDLR     = 10'd31;
  localparam logic [9:0] W_SCRPAD_B = 10'd33;
  localparam logic [9:0] W_INTCR3   = 10'd39;
  localparam logic [9:0] W_CP2BST   = 10'd53;
  localparam logic [9:0] SEM_FIRST  = 10'd960;
  localparam logic [9:0] SEM_LAST   = 10'd991;

  localparam logic [11:0] WIDE_LO = 12'hE00;
  localparam logic [11:0] WIDE_HI = 12'hF7C;

  localparam logic [4:0] DRAM_LG_MIN   = 5'd27;
  localparam logic [4:0] DRAM_LG_RESET = 5'd29;

  localparam logic [31:0] C_INTCR3_BASE = 32'h0000_1002;
  localparam logic [31:0] C_PDID_GEN2   = 32'h04A3_5850;
  localparam logic [31:0] C_PDID_GEN1   = 32'h04A9_2750;
  localparam logic [31:0] C_W15_GEN2    = 32'h0010_035E;
  localparam logic [31:0] C_W38         = 32'h5A00_F3CF;
  localparam logic [31:0] C_W80         = 32'h0347_30E4;
  localparam logic [31:0] C_RESSR       = 32'h8000_0000;
  localparam logic [31:0] C_SEM         = 32'h0000_0001;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } gcr_state_e;

  function automatic logic [31:0] cold_word(input logic [9:0]  idx,
                                            input logic        layout,
                                            input logic [31:0] straps,
                                            input logic [31:0] mdl,
                                            input logic [4:0]  lg);
    logic [4:0]  lg_sat;
    logic [2:0]  lg_off;
    logic [31:0] v;
    lg_sat = (lg < DRAM_LG_MIN) ? DRAM_LG_MIN : lg;
    lg_off = 3'(lg_sat - DRAM_LG_MIN);
    v = '0;
    if (layout) begin
      case (idx)
        10'd0:      v = C_PDID_GEN2;
        10'd5:      v = 32'h0000_FFFF;
        10'd13:     v = 32'hFFF4_FF30;
        10'd14:     v = 32'h0000_0003;
        10'd15:     v = C_W15_GEN2;
        10'd20:     v = 32'h0000_004E;
        10'd24:     v = 32'h0008_0000;
        10'd27:     v = C_RESSR;
        10'd33:     v = 32'h1 << lg_sat;
        10'd38:     v = C_W38;
        10'd45:     v = 32'hFDC8_0000;
        10'd46:     v = 32'h5200_B130;
        10'd58:     v = 32'h0000_4800;
        10'd79:     v = 32'h0000_0008;
        10'd80:     v = C_W80;
        10'd81:     v = C_W80;
        10'd82:     v = C_W80;
        default:    v = (idx >= SEM_FIRST && idx <= SEM_LAST) ? C_SEM : '0;
      endcase
    end else begin
      case (idx)
        10'd0:      v = C_PDID_GEN1;
        10'd5:      v = 32'h0000_FFFF;
        10'd14:     v = 32'h0000_0003;
        10'd15:     v = 32'h0000_035E;
        10'd20:     v = 32'h0000_004E;
        10'd24:     v = 32'h0008_0000;
        10'd27:     v = C_RESSR;
        10'd30:     v = 32'h0000_00C0;
        10'd38:     v = C_W38;
        10'd79:     v = 32'h0000_0008;
        10'd80:     v = C_W80;
        10'd81:     v = C_W80;
        default:    v = '0;
      endcase
    end
    if (idx == W_PWRON) v = straps;
    if (idx == W_MDLR) v = mdl;
    if (idx == W_INTCR3) v = C_INTCR3_BASE | {21'b0, lg_off, 8'b0};
    return v;
  endfunction

endpackage

// File: rtl/gcr_ram.sv
module gcr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [$clog2(DEPTH)-1:0]           waddr_i,
  input  logic [WIDTH-1:0]                   wdata_i,
  input  logic                               re_i,
  input  logic [$clog2(DEPTH)-1:0]           raddr_i,
  output logic [WIDTH-1:0]                   rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/global_control_register_file.sv
// Global control register bank. Words live in two 32-bit synchronous RAMs
// (even and odd words), so an 8-byte access to a word pair is one RAM access.
// The accepting cycle of an access launches the RAM read. The execute state
// modifies, writes back and loads the result register, and the block then
// returns to idle, where the next word can be taken; a result that has not
// been taken holds the block in its execute state. After reset, and after
// each reload word, the bank is refilled from its cold values at one word
// pair per cycle, ceil(NUM_REGS/2) word pairs (496 at the default size); no
// input word is taken meanwhile. The result of a reload is made valid as the
// refill starts. Configuration writes through the APB port are taken at any
// time and apply at the refill of the next reload word.
`include "global_control_register_file_defines.svh"
module global_control_register_file import gcr_pkg::*; #(
  parameter int unsigned NUM_REGS = 992,
  parameter bit          LAYOUT   = 1'b1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [11:0]       byte_offset_i,
  input  logic              wide_access_i,
  input  logic [63:0]       write_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       read_data_o,
  output logic [1:0]        status_o
);

  localparam int unsigned ROWS = (NUM_REGS + 1) / 2;
  localparam int unsigned RW   = $clog2(ROWS);

  // config registers and their snapshot for the refill
  logic [31:0] straps_q, mdl_q, fill_straps_q, fill_mdl_q;
  logic [4:0]  dram_lg_q, fill_lg_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      straps_q  <= '0;
      mdl_q     <= '0;
      dram_lg_q <= DRAM_LG_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        CFG_STRAPS: straps_q  <= pwdata;
        CFG_MDL:    mdl_q     <= pwdata;
        CFG_DRAM:   dram_lg_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      CFG_STRAPS: prdata = straps_q;
      CFG_MDL:    prdata = mdl_q;
      CFG_DRAM:   prdata = {27'b0, dram_lg_q};
      default:    prdata = '0;
    endcase
  end

  // control
  gcr_state_e    state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic          exec_go, sweep_en, snap_en;

  logic [1:0]  action_q;
  logic [11:0] off_q;
  logic        wide_q;
  logic [63:0] data_q;

  logic        out_valid_q;
  logic [63:0] read_data_q;
  logic [1:0]  status_q;

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    in_ready_o = 1'b0;
    exec_go    = 1'b0;
    sweep_en   = 1'b0;
    snap_en    = 1'b0;
    unique case (state_q)
      ST_SWEEP: begin
        sweep_en = 1'b1;
        if (row_q == RW'(ROWS - 1)) begin
          row_d   = '0;
          state_d = ST_IDLE;
        end else begin
          row_d = row_q + RW'(1);
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          exec_go = 1'b1;
          if (action_q == ACT_RELOAD) begin
            snap_en = 1'b1;
            row_d   = '0;
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      row_q         <= '0;
      fill_straps_q <= '0;
      fill_mdl_q    <= '0;
      fill_lg_q     <= DRAM_LG_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      if (snap_en) begin
        fill_straps_q <= straps_q;
        fill_mdl_q    <= mdl_q;
        fill_lg_q     <= dram_lg_q;
      end
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      off_q    <= byte_offset_i;
      wide_q   <= wide_access_i;
      data_q   <= write_data_i;
    end
  end

  // execute
  logic [31:0] rd_even, rd_odd, old_word, new_word;
  logic [9:0]  reg_idx;
  logic        reg_ok, wide_ok, read_only;
  logic [63:0] exec_rdata;
  logic [1:0]  exec_status;
  logic        exec_we_even, exec_we_odd;
  logic [31:0] exec_wd_even, exec_wd_odd;

  assign reg_idx   = off_q[11:2];
  assign reg_ok    = {1'b0, reg_idx} < 11'(NUM_REGS);
  assign wide_ok   = (off_q[2:0] == 3'b000) && (off_q >= WIDE_LO) && (off_q < WIDE_HI) &&
                     (({1'b0, reg_idx} + 11'd1) < 11'(NUM_REGS));
  assign read_only = (reg_idx == W_PDID) || (reg_idx == W_PWRON) || (reg_idx == W_INTSR);
  assign old_word  = reg_idx[0] ? rd_odd : rd_even;

  always_comb begin
    if (reg_idx == W_RESSR || reg_idx == W_CP2BST) begin
      new_word = old_word & ~data_q[31:0];
    end else if (reg_idx == W_RLOCKR1 || reg_idx == W_MDLR) begin
      new_word = old_word | data_q[31:0];
    end else begin
      new_word = data_q[31:0];
    end
  end

  always_comb begin
    exec_rdata   = '0;
    exec_status  = STAT_OK;
    exec_we_even = 1'b0;
    exec_we_odd  = 1'b0;
    exec_wd_even = new_word;
    exec_wd_odd  = new_word;
    if (action_q == ACT_RELOAD) begin
      exec_status = STAT_OK;
    end else if (action_q == ACT_BAD || !reg_ok) begin
      exec_status = STAT_REJECT;
    end else if (!wide_q) begin
      if (off_q[1:0] != 2'b00) begin
        exec_status = STAT_REJECT;
      end else if (action_q == ACT_READ) begin
        exec_rdata = {32'b0, old_word};
      end else if (read_only) begin
        exec_status = STAT_RO;
      end else begin
        exec_we_even = !reg_idx[0];
        exec_we_odd  = reg_idx[0];
      end
    end else begin
      if (!wide_ok) begin
        exec_status = STAT_REJECT;
      end else if (action_q == ACT_READ) begin
        exec_rdata = {rd_odd, rd_even};
      end else begin
        exec_we_even = 1'b1;
        exec_we_odd  = 1'b1;
        exec_wd_even = data_q[31:0];
        exec_wd_odd  = data_q[63:32];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      read_data_q <= exec_rdata;
      status_q    <= exec_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign status_o    = status_q;

  // memories
  logic          we_even, we_odd, re;
  logic [RW-1:0] waddr, raddr;
  logic [31:0]   wd_even, wd_odd;

  assign re      = in_valid_i && in_ready_o;
  assign raddr   = RW'(byte_offset_i[11:3]);
  assign we_even = sweep_en || (exec_go && exec_we_even);
  assign we_odd  = sweep_en || (exec_go && exec_we_odd);
  assign waddr   = sweep_en ? row_q : RW'(off_q[11:3]);
  assign wd_even = sweep_en ?
                   cold_word(10'({row_q, 1'b0}), LAYOUT, fill_straps_q, fill_mdl_q, fill_lg_q) :
                   exec_wd_even;
  assign wd_odd  = sweep_en ?
                   cold_word(10'({row_q, 1'b1}), LAYOUT, fill_straps_q, fill_mdl_q, fill_lg_q) :
                   exec_wd_odd;

  gcr_ram #(
    .WIDTH(32),
    .DEPTH(ROWS)
  ) u_ram_even (
    .clk_i  (clk_i),
    .we_i   (we_even),
    .waddr_i(waddr),
    .wdata_i(wd_even),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd_even)
  );

  gcr_ram #(
    .WIDTH(32),
    .DEPTH(ROWS)
  ) u_ram_odd (
    .clk_i  (clk_i),
    .we_i   (we_odd),
    .waddr_i(waddr),
    .wdata_i(wd_odd),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd_odd)
  );

  `GCR_ASSERT_IMP(a_no_accept_in_sweep, state_q == ST_SWEEP, !in_ready_o, "word accepted during refill")
  `GCR_ASSERT_IMP(a_no_write_idle, state_q == ST_IDLE, !(we_even || we_odd), "RAM write while idle")
  `GCR_ASSERT_NXT(a_accept_exec, in_valid_i && in_ready_o, state_q == ST_EXEC, "accept did not start execute")
  `GCR_ASSERT_IMP(a_ro_no_write, exec_go && exec_status == STAT_RO, !(we_even || we_odd), "read-only word written")
  `GCR_ASSERT_NXT(a_reload_sweep, exec_go && action_q == ACT_RELOAD, state_q == ST_SWEEP && row_q == '0, "reload did not start refill")

endmodule
